>>> hdl/lcf_pkg.sv
`timescale 1ns / 1ps
package lcf_pkg;

  localparam int LCF_COORD_BITS     = 20;
  localparam int LCF_AXIS_FRAC_BITS = 14;
  localparam int LCF_ANCHOR_BITS    = 20;
  localparam int LCF_AXIS_BITS      = 16;
  localparam int LCF_SPACING_BITS   = 19;
  localparam int LCF_ADDR_BITS      = 6;
  localparam int LCF_DATA_BITS      = 64;

  // register indexes, at byte address 8*index
  localparam logic [2:0] REG_ANCHOR  = 3'd0;
  localparam logic [2:0] REG_AXIS_U  = 3'd1;
  localparam logic [2:0] REG_AXIS_V  = 3'd2;
  localparam logic [2:0] REG_AXIS_W  = 3'd3;
  localparam logic [2:0] REG_SPACING = 3'd4;

  localparam logic [59:0] RST_ANCHOR  = 60'd0;
  localparam logic [47:0] RST_AXIS_U  = 48'd16384;
  localparam logic [47:0] RST_AXIS_V  = 48'd1073741824;
  localparam logic [47:0] RST_AXIS_W  = 48'd70368744177664;
  localparam logic [18:0] RST_SPACING = 19'd640;

  localparam logic [2:0] FACE_NEAR_U = 3'd0;
  localparam logic [2:0] FACE_NEAR_V = 3'd1;
  localparam logic [2:0] FACE_NEAR_W = 3'd2;
  localparam logic [2:0] FACE_FAR_U  = 3'd3;
  localparam logic [2:0] FACE_FAR_V  = 3'd4;
  localparam logic [2:0] FACE_FAR_W  = 3'd5;

  typedef struct packed {
    logic signed [LCF_COORD_BITS-1:0] point_x;
    logic signed [LCF_COORD_BITS-1:0] point_y;
    logic signed [LCF_COORD_BITS-1:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic signed [LCF_COORD_BITS-1:0] cell_x;
    logic signed [LCF_COORD_BITS-1:0] cell_y;
    logic signed [LCF_COORD_BITS-1:0] cell_z;
    logic signed [LCF_COORD_BITS-1:0] match_x;
    logic signed [LCF_COORD_BITS-1:0] match_y;
    logic signed [LCF_COORD_BITS-1:0] match_z;
    logic signed [LCF_COORD_BITS-1:0] offset_u;
    logic signed [LCF_COORD_BITS-1:0] offset_v;
    logic signed [LCF_COORD_BITS-1:0] offset_w;
    logic [2:0]                       face_index;
  } out_word_t;

endpackage

>>> hdl/lattice_cell_fold_nearest_face.sv
`timescale 1ns / 1ps
// pipeline from start to out_valid: offset, products, dot product, magnitude, D remainder
// stages (26 at default widths), fold, face, rebuild products, rebuild sums, output; the d mod
// spacing divider retires one quotient bit per stage; throughput: one point per cycle, busy
// never rises; results are strobed for one cycle and the receiver cannot stall
// reset: synchronous active-low rst_n clears the valid bits and loads register defaults
module lattice_cell_fold_nearest_face
  import lcf_pkg::*;
#(
  parameter int AXIS_FRAC_BITS = LCF_AXIS_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  in_word_t                 in_data,
  output logic                     out_valid,
  output out_word_t                out_data,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [LCF_ADDR_BITS-1:0] paddr,
  input  logic [LCF_DATA_BITS-1:0] pwdata,
  output logic [LCF_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int CB   = LCF_COORD_BITS;
  localparam int F    = AXIS_FRAC_BITS;
  localparam int AW   = LCF_ANCHOR_BITS;
  localparam int XW   = LCF_AXIS_BITS;
  localparam int SPW  = LCF_SPACING_BITS;
  localparam int DIFW = ((CB > AW) ? CB : AW) + 1;
  localparam int PW   = DIFW + XW;
  localparam int SW   = PW + 3;
  localparam int DW   = SW - F;
  localparam int RW   = SPW + 1;
  localparam int CW   = SPW + 1;
  localparam int PQ   = XW + CW + 1;
  localparam int QW   = PQ + 3;
  localparam int RQ   = QW - F;
  localparam int TW   = ((RQ > AW) ? RQ : AW) + 1;
  localparam int LAT  = 9 + DW;

  localparam logic signed [TW-1:0] SAT_HI = TW'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [TW-1:0] SAT_LO = TW'(-(64'sd1 <<< (CB - 1)));
  localparam logic signed [SW-1:0] HALF_D = SW'(64'sd1 <<< (F - 1));
  localparam logic signed [QW-1:0] HALF_Q = QW'(64'sd1 <<< (F - 1));

  function automatic logic signed [CB-1:0] sat(input logic signed [TW-1:0] v);
    logic signed [CB-1:0] res;
    if (v > SAT_HI) res = SAT_HI[CB-1:0];
    else if (v < SAT_LO) res = SAT_LO[CB-1:0];
    else res = v[CB-1:0];
    return res;
  endfunction

  // configuration registers
  logic [59:0]    anchor_r;
  logic [47:0]    axu_r, axv_r, axw_r;
  logic [SPW-1:0] spacing_r;
  logic           wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_r  <= RST_ANCHOR;
      axu_r     <= RST_AXIS_U;
      axv_r     <= RST_AXIS_V;
      axw_r     <= RST_AXIS_W;
      spacing_r <= RST_SPACING;
    end else if (wr_en) begin
      case (paddr[5:3])
        REG_ANCHOR:  anchor_r  <= pwdata[59:0];
        REG_AXIS_U:  axu_r     <= pwdata[47:0];
        REG_AXIS_V:  axv_r     <= pwdata[47:0];
        REG_AXIS_W:  axw_r     <= pwdata[47:0];
        REG_SPACING: spacing_r <= pwdata[SPW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_ANCHOR:  prdata = {4'd0, anchor_r};
      REG_AXIS_U:  prdata = {16'd0, axu_r};
      REG_AXIS_V:  prdata = {16'd0, axv_r};
      REG_AXIS_W:  prdata = {16'd0, axw_r};
      REG_SPACING: prdata = {{(LCF_DATA_BITS-SPW){1'b0}}, spacing_r};
      default:     prdata = '0;
    endcase
  end

  // unpacked views; the user must only move config while the pipe is empty, the block does not enforce it
  logic signed [AW-1:0] anc [3];
  logic signed [XW-1:0] ax  [3][3];
  logic [SPW-1:0]       s_eff;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      anc[i]   = anchor_r[AW*i +: AW];
      ax[0][i] = axu_r[XW*i +: XW];
      ax[1][i] = axv_r[XW*i +: XW];
      ax[2][i] = axw_r[XW*i +: XW];
    end
    // zero spacing behaves as one
    s_eff = (spacing_r == '0) ? SPW'(1) : spacing_r;
  end

  // stage 1: offset from anchor
  logic                   v1_r;
  logic signed [DIFW-1:0] diff_r [3];
  logic signed [CB-1:0]   pt [3];

  assign pt[0] = in_data.point_x[CB-1:0];
  assign pt[1] = in_data.point_y[CB-1:0];
  assign pt[2] = in_data.point_z[CB-1:0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) diff_r[i] <= DIFW'(pt[i]) - DIFW'(anc[i]);
  end

  // stage 2: axis products
  logic                 v2_r;
  logic signed [PW-1:0] prod_r [3][3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++) prod_r[k][i] <= diff_r[i] * ax[k][i];
  end

  // stage 3: dot product, round half up
  logic                 v3_r;
  logic signed [DW-1:0] d_r [3];
  logic signed [SW-1:0] acc [3];

  always_comb begin
    for (int k = 0; k < 3; k++)
      acc[k] = SW'(prod_r[k][0]) + SW'(prod_r[k][1]) + SW'(prod_r[k][2]) + HALF_D;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) d_r[k] <= DW'(acc[k] >>> F);
  end

  // stage 4 onward: magnitude, then one remainder bit per stage
  logic          dv_r  [DW+1];
  logic          neg_r [DW+1][3];
  logic [DW-1:0] mag_r [DW+1][3];
  logic [RW-1:0] rem_r [DW+1][3];
  logic [RW-1:0] trial [DW][3];

  always_comb begin
    for (int j = 0; j < DW; j++)
      for (int k = 0; k < 3; k++)
        trial[j][k] = {rem_r[j][k][RW-2:0], mag_r[j][k][DW-1-j]};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      neg_r[0][k] <= d_r[k][DW-1];
      mag_r[0][k] <= d_r[k][DW-1] ? (~d_r[k] + DW'(1)) : d_r[k];
      rem_r[0][k] <= '0;
    end
    for (int j = 0; j < DW; j++)
      for (int k = 0; k < 3; k++) begin
        neg_r[j+1][k] <= neg_r[j][k];
        mag_r[j+1][k] <= mag_r[j][k];
        rem_r[j+1][k] <= (trial[j][k] >= RW'(s_eff)) ? trial[j][k] - RW'(s_eff)
                                                     : trial[j][k];
      end
  end

  // fold negatives up into [0, s)
  logic           vc_r;
  logic [SPW-1:0] c_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++)
      c_r[k] <= (neg_r[DW][k] && rem_r[DW][k] != '0) ? s_eff - rem_r[DW][k][SPW-1:0]
                                                     : rem_r[DW][k][SPW-1:0];
  end

  // nearest face, projected coordinates, wrapped offsets
  logic                 vf_r;
  logic [2:0]           face_r;
  logic [CW-1:0]        cf_r  [3];
  logic [CW-1:0]        cp_r  [3];
  logic signed [TW-1:0] off_r [3];
  logic [SPW-1:0]       face_dist [6];
  logic [SPW-1:0]       best;
  logic [2:0]           face;
  logic [CW-1:0]        cp   [3];
  logic signed [TW-1:0] off  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      face_dist[k]   = c_r[k];
      face_dist[k+3] = s_eff - c_r[k];
    end
    best = face_dist[0];
    face = FACE_NEAR_U;
    for (int k = 1; k < 6; k++)
      if (face_dist[k] < best) begin
        best = face_dist[k];
        face = 3'(k);
      end
    for (int k = 0; k < 3; k++) begin
      cp[k]  = CW'(c_r[k]);
      off[k] = ({c_r[k], 1'b0} > {1'b0, s_eff}) ? TW'(c_r[k]) - TW'(s_eff) : TW'(c_r[k]);
    end
    unique case (face)
      FACE_NEAR_U: cp[0] = '0;
      FACE_NEAR_V: cp[1] = '0;
      FACE_NEAR_W: cp[2] = '0;
      FACE_FAR_U:  cp[0] = CW'(s_eff);
      FACE_FAR_V:  cp[1] = CW'(s_eff);
      FACE_FAR_W:  cp[2] = CW'(s_eff);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    face_r <= face;
    for (int k = 0; k < 3; k++) begin
      cf_r[k]  <= CW'(c_r[k]);
      cp_r[k]  <= cp[k];
      off_r[k] <= off[k];
    end
  end

  // rebuild products
  logic                 vp_r;
  logic [2:0]           face2_r;
  logic signed [TW-1:0] off2_r [3];
  logic signed [PQ-1:0] pc_r [3][3];
  logic signed [PQ-1:0] pm_r [3][3];

  always_ff @(posedge clk) begin
    face2_r <= face_r;
    for (int k = 0; k < 3; k++) off2_r[k] <= off_r[k];
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) begin
        pc_r[i][k] <= ax[k][i] * $signed({1'b0, cf_r[k]});
        pm_r[i][k] <= ax[k][i] * $signed({1'b0, cp_r[k]});
      end
  end

  // rebuild sums, round half up
  logic                 vs_r;
  logic [2:0]           face3_r;
  logic signed [TW-1:0] off3_r [3];
  logic signed [RQ-1:0] qc_r [3];
  logic signed [RQ-1:0] qm_r [3];
  logic signed [QW-1:0] qc [3];
  logic signed [QW-1:0] qm [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = QW'(pc_r[i][0]) + QW'(pc_r[i][1]) + QW'(pc_r[i][2]) + HALF_Q;
      qm[i] = QW'(pm_r[i][0]) + QW'(pm_r[i][1]) + QW'(pm_r[i][2]) + HALF_Q;
    end
  end

  always_ff @(posedge clk) begin
    face3_r <= face2_r;
    for (int i = 0; i < 3; i++) begin
      off3_r[i] <= off2_r[i];
      qc_r[i]   <= RQ'(qc[i] >>> F);
      qm_r[i]   <= RQ'(qm[i] >>> F);
    end
  end

  // output word: add anchor back and saturate
  logic      out_valid_r;
  out_word_t out_r;

  always_ff @(posedge clk) begin
    out_r.cell_x     <= LCF_COORD_BITS'(sat(TW'(anc[0]) + TW'(qc_r[0])));
    out_r.cell_y     <= LCF_COORD_BITS'(sat(TW'(anc[1]) + TW'(qc_r[1])));
    out_r.cell_z     <= LCF_COORD_BITS'(sat(TW'(anc[2]) + TW'(qc_r[2])));
    out_r.match_x    <= LCF_COORD_BITS'(sat(TW'(anc[0]) + TW'(qm_r[0])));
    out_r.match_y    <= LCF_COORD_BITS'(sat(TW'(anc[1]) + TW'(qm_r[1])));
    out_r.match_z    <= LCF_COORD_BITS'(sat(TW'(anc[2]) + TW'(qm_r[2])));
    out_r.offset_u   <= LCF_COORD_BITS'(sat(off3_r[0]));
    out_r.offset_v   <= LCF_COORD_BITS'(sat(off3_r[1]));
    out_r.offset_w   <= LCF_COORD_BITS'(sat(off3_r[2]));
    out_r.face_index <= face3_r;
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      for (int j = 0; j <= DW; j++) dv_r[j] <= 1'b0;
      vc_r        <= 1'b0;
      vf_r        <= 1'b0;
      vp_r        <= 1'b0;
      vs_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= start && !busy;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      dv_r[0]     <= v3_r;
      for (int j = 0; j < DW; j++) dv_r[j+1] <= dv_r[j];
      vc_r        <= dv_r[DW];
      vf_r        <= vc_r;
      vp_r        <= vf_r;
      vs_r        <= vp_r;
      out_valid_r <= vs_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n, LAT)) |-> $past(start && !busy, LAT))
    else $error("result without matching accepted word");

  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.face_index <= FACE_FAR_W))
    else $error("face index out of range");

  a_face_stage: assert property (@(posedge clk) disable iff (!rst_n)
    vs_r |=> (out_valid && out_data.face_index == $past(face3_r)))
    else $error("face index lost in output stage");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[DW] |-> (rem_r[DW][0] < RW'(s_eff) && rem_r[DW][1] < RW'(s_eff)
                  && rem_r[DW][2] < RW'(s_eff)))
    else $error("remainder not below spacing");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import lcf_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_data = '0;
  logic out_valid;
  out_word_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [LCF_ADDR_BITS-1:0] paddr = '0;
  logic [LCF_DATA_BITS-1:0] pwdata = '0;
  logic [LCF_DATA_BITS-1:0] prdata;
  logic pready;

  lattice_cell_fold_nearest_face u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // lattice settings mirrored on the bench side
  logic [59:0] lat_anchor = RST_ANCHOR;
  logic [47:0] lat_axis [3] = '{RST_AXIS_U, RST_AXIS_V, RST_AXIS_W};
  logic [18:0] lat_spacing = RST_SPACING;

  in_word_t  point_q [$];
  out_word_t fold_q [$];
  int mismatches = 0;
  int cycles = 0;
  bit driver_hold = 1'b0;
  int gap_left = 0;

  function automatic longint round_q14(longint x);
    longint y;
    y = x + (64'sd1 <<< (LCF_AXIS_FRAC_BITS - 1));
    return y >>> LCF_AXIS_FRAC_BITS;
  endfunction

  function automatic logic [19:0] clamp_coord(longint v);
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v[19:0];
  endfunction

  function automatic out_word_t fold_point(in_word_t p);
    out_word_t r;
    longint anc [3], pt [3], ax [3][3], c [3], cp [3];
    longint s, best, acc, d, m, qc, qm;
    int face;
    s = (lat_spacing == 0) ? 1 : longint'(lat_spacing);
    pt[0] = p.point_x; pt[1] = p.point_y; pt[2] = p.point_z;
    for (int i = 0; i < 3; i++) begin
      anc[i] = longint'($signed(lat_anchor[i*20 +: 20]));
      for (int k = 0; k < 3; k++) ax[k][i] = longint'($signed(lat_axis[k][i*16 +: 16]));
    end
    for (int k = 0; k < 3; k++) begin
      acc = 0;
      for (int i = 0; i < 3; i++) acc += (pt[i] - anc[i]) * ax[k][i];
      d = round_q14(acc);
      m = d % s;
      if (m < 0) m += s;
      c[k] = m;
    end
    best = c[0]; face = 0;
    for (int k = 0; k < 6; k++) begin
      d = (k < 3) ? c[k] : s - c[k-3];
      if (d < best) begin
        best = d; face = k;
      end
    end
    for (int k = 0; k < 3; k++) cp[k] = c[k];
    cp[face % 3] = (face < 3) ? 0 : s;
    for (int i = 0; i < 3; i++) begin
      qc = 0; qm = 0;
      for (int k = 0; k < 3; k++) begin
        qc += ax[k][i] * c[k];
        qm += ax[k][i] * cp[k];
      end
      case (i)
        0: begin r.cell_x = clamp_coord(anc[i] + round_q14(qc));
          r.match_x = clamp_coord(anc[i] + round_q14(qm)); end
        1: begin r.cell_y = clamp_coord(anc[i] + round_q14(qc));
          r.match_y = clamp_coord(anc[i] + round_q14(qm)); end
        default: begin r.cell_z = clamp_coord(anc[i] + round_q14(qc));
          r.match_z = clamp_coord(anc[i] + round_q14(qm)); end
      endcase
    end
    r.offset_u = clamp_coord((2*c[0] > s) ? c[0] - s : c[0]);
    r.offset_v = clamp_coord((2*c[1] > s) ? c[1] - s : c[1]);
    r.offset_w = clamp_coord((2*c[2] > s) ? c[2] - s : c[2]);
    r.face_index = face[2:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n || driver_hold) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // word still pending
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (point_q.size() > 0) begin
      in_word_t p;
      p = point_q.pop_front();
      in_data <= p;
      start <= 1'b1;
      fold_q.push_back(fold_point(p));
      if ($urandom_range(0, 2) == 0)
        gap_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (fold_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected word %h", out_data);
      end else begin
        out_word_t e;
        e = fold_q.pop_front();
        if (e !== out_data) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("mismatch exp %h got %h", e, out_data);
        end
      end
    end
    if (cycles > 400000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= LCF_ADDR_BITS'(8 * idx); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ANCHOR:  lat_anchor = val[59:0];
      REG_AXIS_U:  lat_axis[0] = val[47:0];
      REG_AXIS_V:  lat_axis[1] = val[47:0];
      REG_AXIS_W:  lat_axis[2] = val[47:0];
      default:     lat_spacing = val[18:0];
    endcase
  endtask

  task automatic drain_all();
    while (point_q.size() > 0 || fold_q.size() > 0 || start) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [19:0] rand_coord(bit near_edge);
    if (near_edge) return ($urandom_range(0, 1)) ? 20'(20'h7ffff - $urandom_range(0, 3))
                                                  : 20'(20'h80000 + $urandom_range(0, 3));
    return $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($signed($urandom_range(0, 4000)) - 2000);
  endfunction

  function automatic logic [47:0] rand_axis();
    logic [47:0] a;
    case ($urandom_range(0, 3))
      0: a = {16'(-16384 * $urandom_range(0, 1)), 16'd0, 16'd16384};
      1: a = {16'($urandom_range(0, 16384)), 16'($urandom_range(0, 16384)),
              16'($urandom_range(0, 16384))};
      default: a = 48'({$urandom, $urandom});
    endcase
    return a;
  endfunction

  initial begin
    in_word_t p;
    logic [18:0] sp_set [6] = '{19'd640, 19'd1, 19'd0, 19'h7ffff, 19'd7, 19'd100};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, faces and ties at the default lattice
    for (int i = 0; i < 20; i++) begin
      case (i)
        0: p = '{20'h7ffff, 20'h7ffff, 20'h7ffff};
        1: p = '{20'h80000, 20'h80000, 20'h80000};
        2: p = '{20'd0, 20'd0, 20'd0};
        3: p = '{20'd320, 20'd320, 20'd320};
        4: p = '{20'd639, 20'd5, 20'd100};
        5: p = '{20'd100, 20'd639, 20'd300};
        6: p = '{20'd300, 20'd200, 20'd1};
        7: p = '{20'd300, 20'd200, 20'd638};
        8: p = '{20'h7ffff, 20'd0, 20'h80000};
        9: p = '{-20'sd1, -20'sd641, -20'sd320};
        default: p = '{rand_coord(1), rand_coord(0), rand_coord(1)};
      endcase
      point_q.push_back(p);
    end
    drain_all();
    // sweep of lattice settings, extremes first
    for (int ph = 0; ph < 14; ph++) begin
      reg_write(REG_SPACING, (ph < 6) ? {45'd0, sp_set[ph]} : 64'($urandom_range(1, 2000)));
      reg_write(REG_ANCHOR, (ph == 1) ? 64'h0fff_ffff_ffff_ffff :
                (ph == 2) ? 64'h0800_0080_0008_0000 : {$urandom, $urandom} & 64'h0fff_ffff_ffff_ffff);
      reg_write(REG_AXIS_U, (ph == 3) ? 64'hffff_ffff_ffff :
                (ph == 4) ? 64'h8000_8000_8000 : 64'(rand_axis()));
      reg_write(REG_AXIS_V, (ph == 3) ? 64'h7fff_7fff_7fff : 64'(rand_axis()));
      reg_write(REG_AXIS_W, (ph == 0) ? 64'({16'd16384, 32'd0}) : 64'(rand_axis()));
      for (int i = 0; i < 100; i++)
        point_q.push_back('{rand_coord(i % 9 == 0), rand_coord(i % 11 == 0), rand_coord(i % 13 == 0)});
      if (ph == 5) begin
        while (point_q.size() > 50) @(posedge clk);
        driver_hold = 1'b1;
        while (fold_q.size() > 0) @(posedge clk);
        driver_hold = 1'b0;
      end
      drain_all();
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
hdl/lcf_pkg.sv
hdl/lattice_cell_fold_nearest_face.sv
tb/tb.sv
